// File: design/wrsi_pkg.sv
// Package for the Wilder RSI block: widths, constants and the sequencer state type.
package wrsi_pkg;

  // Price and fixed-point formats
  localparam int PRICE_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int AVG_W      = 48;
  localparam int PER_W      = 8;
  localparam int RSI_W      = 23;

  // Product of an average and N-1
  localparam int PROD_W = AVG_W + PER_W;

  // Shared divider: for the RSI the dividend holds 100 * G * 2^FRAC, the divisor G + L
  localparam int DIV_W = AVG_W + FRAC_BITS + 7;
  localparam int DVS_W = AVG_W + 1;
  localparam int CNT_W = $clog2(DIV_W);

  localparam logic [PRICE_BITS-1:0] PRICE_MASK = PRICE_BITS'((64'd1 << PRICE_BITS) - 64'd1);
  localparam logic [RSI_W-1:0]      RSI_FULL   = RSI_W'(100 * (2 ** FRAC_BITS));
  localparam logic [PER_W-1:0]      PERIOD_RESET = PER_W'(14);
  localparam logic [PER_W-1:0]      PERIOD_MIN   = PER_W'(2);
  localparam logic [PER_W-1:0]      WARM_MAX     = {PER_W{1'b1}};

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_G,
    ST_SET_G,
    ST_RUN_G,
    ST_MUL_L,
    ST_SET_L,
    ST_RUN_L,
    ST_SET_R,
    ST_RUN_R,
    ST_EMIT
  } wrsi_state_t;

endpackage

// File: design/wilder_relative_strength_index.sv
// Top level of the Wilder RSI block: sequencer, state and output register.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+--------------------------------------
//  in      | input     | in_valid / in_ready   | in_close_price[31:0], in_series_start
//  out     | output    | out_valid / out_ready | out_rsi_value[22:0] (Q7.16)
//  cfg     | input     | cfg_valid / cfg_ready | cfg_smoothing_period[7:0]
//
// The first price of a series and every warm-up price but the last give no result.
// A request that gives a result runs three divisions in series on the shared divider, or
// two when the loss average is zero, one quotient bit per cycle, DIV_W = 71 steps each.
// Reset is synchronous: period 14, all series state cleared, no clearing pass.
// in_ready is low while a request is in work; a finished result waits in the output
// register, and the next result waits until it is taken. cfg_ready is always high.
module wilder_relative_strength_index import wrsi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PRICE_BITS-1:0] in_close_price,
  input  logic                  in_series_start,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [RSI_W-1:0]      out_rsi_value,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [PER_W-1:0]      cfg_smoothing_period
);

  wrsi_state_t state_r, state_nxt;

  logic [PER_W-1:0]      period_r, period_nxt;
  logic [PRICE_BITS-1:0] prev_r, prev_nxt;
  logic                  have_prev_r, have_prev_nxt;
  logic [PER_W-1:0]      warm_r, warm_nxt;
  logic [AVG_W-1:0]      gavg_r, gavg_nxt;
  logic [AVG_W-1:0]      lavg_r, lavg_nxt;
  logic                  avg_rdy_r, avg_rdy_nxt;
  logic [PRICE_BITS-1:0] gain_r, gain_nxt;
  logic [PRICE_BITS-1:0] loss_r, loss_nxt;
  logic [PROD_W-1:0]     prod_r, prod_nxt;
  logic [RSI_W-1:0]      rsi_res_r, rsi_res_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [RSI_W-1:0]      out_rsi_r, out_rsi_nxt;

  logic [PER_W-1:0]      per_n;
  logic [PER_W-1:0]      per_less1;
  logic [PRICE_BITS-1:0] price;
  logic [PER_W-1:0]      warm_inc;
  logic [DIV_W-1:0]      g_frac;
  logic [DIV_W-1:0]      l_frac;

  logic             div_start;
  logic [DIV_W-1:0] div_dividend;
  logic [DVS_W-1:0] div_divisor;
  logic             div_done;
  logic [DIV_W-1:0] div_quot;

  wrsi_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  // Effective period, never below two
  assign per_n     = (period_r < PERIOD_MIN) ? PERIOD_MIN : period_r;
  assign per_less1 = per_n - 1'b1;
  assign price     = in_close_price & PRICE_MASK;
  assign warm_inc  = (warm_r == WARM_MAX) ? warm_r : PER_W'(warm_r + 1'b1);
  assign g_frac    = DIV_W'({gavg_r, {FRAC_BITS{1'b0}}});
  assign l_frac    = DIV_W'({lavg_r, {FRAC_BITS{1'b0}}});

  assign in_ready      = (state_r == ST_IDLE);
  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_rsi_value = out_rsi_r;

  // Sequencer: next state, datapath updates, divider operands
  always_comb begin
    state_nxt     = state_r;
    period_nxt    = period_r;
    prev_nxt      = prev_r;
    have_prev_nxt = have_prev_r;
    warm_nxt      = warm_r;
    gavg_nxt      = gavg_r;
    lavg_nxt      = lavg_r;
    avg_rdy_nxt   = avg_rdy_r;
    gain_nxt      = gain_r;
    loss_nxt      = loss_r;
    prod_nxt      = prod_r;
    rsi_res_nxt   = rsi_res_r;
    out_valid_nxt = out_valid_r;
    out_rsi_nxt   = out_rsi_r;
    div_start     = 1'b0;
    div_dividend  = '0;
    div_divisor   = '0;

    if (cfg_valid) begin
      period_nxt = cfg_smoothing_period;
    end

    // result taken downstream
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_series_start || !have_prev_r) begin
            // new series: keep the price only
            prev_nxt      = price;
            have_prev_nxt = 1'b1;
            warm_nxt      = '0;
            gavg_nxt      = '0;
            lavg_nxt      = '0;
            avg_rdy_nxt   = 1'b0;
          end else begin
            gain_nxt = (price > prev_r) ? price - prev_r : '0;
            loss_nxt = (price > prev_r) ? '0 : prev_r - price;
            prev_nxt = price;
            if (!avg_rdy_r) begin
              // warm-up: plain sums of changes
              gavg_nxt = gavg_r + AVG_W'(gain_nxt);
              lavg_nxt = lavg_r + AVG_W'(loss_nxt);
              warm_nxt = warm_inc;
              if (warm_inc >= per_n) begin
                state_nxt = ST_MUL_G;
              end
            end else begin
              state_nxt = ST_MUL_G;
            end
          end
        end
      end
      ST_MUL_G: begin
        prod_nxt  = PROD_W'(gavg_r) * PROD_W'(per_less1);
        state_nxt = ST_SET_G;
      end
      ST_SET_G: begin
        div_start    = 1'b1;
        div_divisor  = DVS_W'(per_n);
        div_dividend = avg_rdy_r ?
                       DIV_W'(prod_r) + DIV_W'({gain_r, {FRAC_BITS{1'b0}}}) : g_frac;
        state_nxt    = ST_RUN_G;
      end
      ST_RUN_G: begin
        if (div_done) begin
          gavg_nxt  = div_quot[AVG_W-1:0];
          state_nxt = ST_MUL_L;
        end
      end
      ST_MUL_L: begin
        prod_nxt  = PROD_W'(lavg_r) * PROD_W'(per_less1);
        state_nxt = ST_SET_L;
      end
      ST_SET_L: begin
        div_start    = 1'b1;
        div_divisor  = DVS_W'(per_n);
        div_dividend = avg_rdy_r ?
                       DIV_W'(prod_r) + DIV_W'({loss_r, {FRAC_BITS{1'b0}}}) : l_frac;
        state_nxt    = ST_RUN_L;
      end
      ST_RUN_L: begin
        if (div_done) begin
          lavg_nxt    = div_quot[AVG_W-1:0];
          avg_rdy_nxt = 1'b1;
          state_nxt   = ST_SET_R;
        end
      end
      ST_SET_R: begin
        if (lavg_r == '0) begin
          // no losses: full scale
          rsi_res_nxt = RSI_FULL;
          state_nxt   = ST_EMIT;
        end else begin
          // 100 * G * 2^FRAC / (G + L)
          div_start    = 1'b1;
          div_dividend = (g_frac << 6) + (g_frac << 5) + (g_frac << 2);
          div_divisor  = DVS_W'(gavg_r) + DVS_W'(lavg_r);
          state_nxt    = ST_RUN_R;
        end
      end
      ST_RUN_R: begin
        if (div_done) begin
          rsi_res_nxt = div_quot[RSI_W-1:0];
          state_nxt   = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_rsi_nxt   = rsi_res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Series state and control flops
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r    <= PERIOD_RESET;
      prev_r      <= '0;
      have_prev_r <= 1'b0;
      warm_r      <= '0;
      gavg_r      <= '0;
      lavg_r      <= '0;
      avg_rdy_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      period_r    <= period_nxt;
      prev_r      <= prev_nxt;
      have_prev_r <= have_prev_nxt;
      warm_r      <= warm_nxt;
      gavg_r      <= gavg_nxt;
      lavg_r      <= lavg_nxt;
      avg_rdy_r   <= avg_rdy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working payload
  always_ff @(posedge clk) begin
    gain_r    <= gain_nxt;
    loss_r    <= loss_nxt;
    prod_r    <= prod_nxt;
    rsi_res_r <= rsi_res_nxt;
    out_rsi_r <= out_rsi_nxt;
  end

  // Divider finishes only while the sequencer waits for it
  a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_RUN_G || state_r == ST_RUN_L || state_r == ST_RUN_R))
    else $error("divider done outside a wait state");

  // A shown result never exceeds full scale
  a_rsi_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_rsi_r <= RSI_FULL))
    else $error("rsi above full scale");

  // Averages are ready only within a running series
  a_rdy_series: assert property (@(posedge clk) disable iff (!rst_n)
    avg_rdy_r |-> have_prev_r)
    else $error("averages ready without a previous price");

  // Leaving the emit state always shows the result
  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && (!out_valid_r || out_ready)) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("result lost on emit");

endmodule

// File: design/wrsi_div.sv
// Shared restoring divider, one quotient bit per cycle.
module wrsi_div import wrsi_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_W - 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0] num_r, num_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;

  logic [DVS_W:0] trial;
  logic [DVS_W:0] diff;
  logic           fits;

  // One trial subtraction per step
  always_comb begin
    trial = {rem_r, num_r[DIV_W-1]};
    diff  = trial - {1'b0, dvs_r};
    fits  = (trial >= {1'b0, dvs_r});

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;

    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      num_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      num_nxt = {num_r[DIV_W-2:0], fits};
      rem_nxt = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      cnt_nxt = CNT_W'(cnt_r + 1'b1);
      if (cnt_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control flops reset, operands do not
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = num_r;

endmodule

// File: verif/tb_wilder_relative_strength_index.sv
// Self-checking testbench for the Wilder RSI block: directed and random price streams.
module tb_wilder_relative_strength_index;
  import wrsi_pkg::*;

  localparam int LATENCY_PAD = 300;    // covers one full three-division request
  localparam int HOLD_CYCLES = 3000;   // long receiver hold-off
  localparam int STALL_LIMIT = 20000;  // cycles without any handshake
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 200;

  // Tracks the series state and holds the RSI values still owed by the block
  class rsi_tracker;
    bit [PER_W-1:0]      period_reg;
    bit [PRICE_BITS-1:0] prev_price;
    bit                  have_prev;
    bit [PER_W-1:0]      warm_cnt;
    bit [AVG_W-1:0]      gain_avg;
    bit [AVG_W-1:0]      loss_avg;
    bit                  avg_ready;
    bit [RSI_W-1:0]      pending_rsi[$];
    int                  mismatch_count;

    function new();
      period_reg     = PERIOD_RESET;
      mismatch_count = 0;
      clear_series();
    endfunction

    function void clear_series();
      prev_price = '0;
      have_prev  = 1'b0;
      warm_cnt   = '0;
      gain_avg   = '0;
      loss_avg   = '0;
      avg_ready  = 1'b0;
    endfunction

    function void set_period(bit [PER_W-1:0] value);
      period_reg = value;
    endfunction

    // Advance the series by one accepted price request
    function void take_price(bit [PRICE_BITS-1:0] price, bit start);
      bit [63:0]      n;
      bit [63:0]      up;
      bit [63:0]      down;
      bit [63:0]      sum;
      bit [79:0]      scaled;
      bit [RSI_W-1:0] want;
      n    = (period_reg < PERIOD_MIN) ? 64'(PERIOD_MIN) : 64'(period_reg);
      up   = '0;
      down = '0;
      if (start) clear_series();
      if (!have_prev) begin
        prev_price = price;
        have_prev  = 1'b1;
        return;
      end
      if (price > prev_price) up = 64'(price - prev_price);
      else down = 64'(prev_price - price);
      prev_price = price;

      if (!avg_ready) begin
        // warm-up: plain sums, then divide by N once enough changes are in
        gain_avg = AVG_W'(64'(gain_avg) + up);
        loss_avg = AVG_W'(64'(loss_avg) + down);
        if (warm_cnt < WARM_MAX) warm_cnt++;
        if (64'(warm_cnt) < n) return;
        gain_avg  = AVG_W'((64'(gain_avg) << FRAC_BITS) / n);
        loss_avg  = AVG_W'((64'(loss_avg) << FRAC_BITS) / n);
        avg_ready = 1'b1;
      end else begin
        gain_avg = AVG_W'((64'(gain_avg) * (n - 64'd1) + (up << FRAC_BITS)) / n);
        loss_avg = AVG_W'((64'(loss_avg) * (n - 64'd1) + (down << FRAC_BITS)) / n);
      end

      // RSI = 100 * G / (G + L), pinned to 100 when there is no loss
      if (loss_avg == '0) begin
        want = RSI_FULL;
      end else begin
        sum    = 64'(gain_avg) + 64'(loss_avg);
        scaled = 80'(64'(gain_avg) * 64'd100) << FRAC_BITS;
        want   = RSI_W'(scaled / 80'(sum));
      end
      pending_rsi = {pending_rsi, want};
    endfunction

    function void check_rsi(bit [RSI_W-1:0] got);
      bit [RSI_W-1:0] want;
      if (pending_rsi.size() == 0) begin
        $display("%0t: RSI result with none outstanding: expected none, got %0d", $time, got);
        mismatch_count++;
      end else begin
        want = pending_rsi.pop_front();
        if (want != got) begin
          $display("%0t: RSI mismatch: expected %0d, got %0d", $time, want, got);
          mismatch_count++;
        end
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [PRICE_BITS-1:0] in_close_price;
  logic                  in_series_start;
  logic                  out_valid;
  logic                  out_ready;
  logic [RSI_W-1:0]      out_rsi_value;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [PER_W-1:0]      cfg_smoothing_period;

  rsi_tracker tracker;
  int         send_idle_pct  = 0;
  int         recv_stall_pct = 0;
  bit         hold_pending   = 1'b0;

  wilder_relative_strength_index dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_close_price       (in_close_price),
    .in_series_start      (in_series_start),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_rsi_value        (out_rsi_value),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_smoothing_period (cfg_smoothing_period)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Offer one price request, hold it until accepted, then maybe go idle
  task automatic offer_price(input logic [PRICE_BITS-1:0] price, input logic start);
    in_close_price  = price;
    in_series_start = start;
    in_valid        = 1'b1;
    do @(posedge clk); while (!in_ready);
    tracker.take_price(price, start);
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    end
  endtask

  // Write N once the block has gone quiet
  task automatic program_period(input logic [PER_W-1:0] value);
    in_valid = 1'b0;
    while (tracker.pending_rsi.size() != 0) @(negedge clk);
    repeat (LATENCY_PAD) @(negedge clk);
    cfg_smoothing_period = value;
    cfg_valid            = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_period(value);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Random series: mostly long enough to get past warm-up, some cut short
  task automatic run_phase(input int budget);
    int                  sent;
    int                  len;
    int                  n_eff;
    int                  sel;
    logic                start;
    logic [PRICE_BITS-1:0] tick;
    sent  = 0;
    tick  = $urandom;
    n_eff = (tracker.period_reg < PERIOD_MIN) ? int'(PERIOD_MIN) : int'(tracker.period_reg);
    while (sent < budget) begin
      if ($urandom_range(99) < 85) len = n_eff + 1 + $urandom_range(1, 30);
      else len = $urandom_range(1, n_eff);
      for (int i = 0; i < len; i++) begin
        if (i == 0) start = ($urandom_range(9) != 0);
        else start = ($urandom_range(199) == 0);
        sel = $urandom_range(99);
        if (sel < 8) tick = $urandom;
        else if (sel < 20) tick = tick;
        else if (sel < 24) tick = sel[0] ? '1 : '0;
        else tick = tick + PRICE_BITS'($urandom_range(4000)) - PRICE_BITS'(2000);
        offer_price(tick, start);
        sent++;
      end
    end
  endtask

  // Receiver: random stalls, one long hold-off on request
  initial begin : receiver
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_ready    = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result checking
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) tracker.check_rsi(out_rsi_value);
  end

  // Watchdog: ends the run when no handshake happens for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("FAIL wilder_relative_strength_index");
    $finish;
  end

  // Main sequence
  initial begin : stimulus
    int           phase_send[4]   = '{0, 77, 0, 16};
    int           phase_recv[4]   = '{0, 0, 77, 16};
    bit [PER_W-1:0] phase_period[PHASES] = '{2, 9, 255, 0, 14, 1, 5, 3};

    tracker              = new();
    rst_n                = 1'b0;
    in_valid             = 1'b0;
    in_close_price       = '0;
    in_series_start      = 1'b0;
    cfg_valid            = 1'b0;
    cfg_smoothing_period = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // first price after reset, extreme swings during warm-up at the reset period
    offer_price('0, 1'b0);
    offer_price('1, 1'b0);
    offer_price('0, 1'b0);
    offer_price('1, 1'b0);
    // shorten N mid warm-up: the next change finishes it
    program_period(8'd3);
    offer_price('1, 1'b0);
    offer_price('0, 1'b0);
    // N of zero acts as two; flat prices give no gain and no loss
    program_period(8'd0);
    offer_price(32'd100, 1'b1);
    offer_price(32'd100, 1'b0);
    offer_price(32'd100, 1'b0);
    offer_price(32'd200, 1'b0);
    offer_price(32'd50, 1'b0);
    // N of one acts as two; falling prices only, then a full-range rise
    program_period(8'd1);
    offer_price(32'd1000, 1'b1);
    offer_price(32'd900, 1'b0);
    offer_price(32'd800, 1'b0);
    offer_price('1, 1'b0);
    offer_price(32'h5555_AAAA, 1'b1);
    offer_price(32'hAAAA_5555, 1'b0);

    // random phases across idling modes and periods
    for (int p = 0; p < PHASES; p++) begin
      program_period(phase_period[p]);
      send_idle_pct  = phase_send[p % 4];
      recv_stall_pct = phase_recv[p % 4];
      if (p == 4) hold_pending = 1'b1;
      run_phase(PHASE_ITEMS);
    end

    in_valid = 1'b0;
    while (tracker.pending_rsi.size() != 0) @(posedge clk);
    repeat (LATENCY_PAD) @(posedge clk);
    if (tracker.mismatch_count == 0 && tracker.pending_rsi.size() == 0)
      $display("PASS wilder_relative_strength_index");
    else
      $display("FAIL wilder_relative_strength_index");
    $finish;
  end

endmodule

// File: sim.f
design/wrsi_pkg.sv
design/wrsi_div.sv
design/wilder_relative_strength_index.sv
verif/tb_wilder_relative_strength_index.sv
